>>> design/acsi_pkg.sv
package acsi_pkg;

    localparam int PARAM_WIDTH_DEF = 16;

    typedef enum logic [3:0] {
        KIND_NONE = 4'd0,
        KIND_SS2  = 4'd1,
        KIND_SS3  = 4'd2,
        KIND_DCS  = 4'd3,
        KIND_CSI  = 4'd4,
        KIND_ST   = 4'd5,
        KIND_OSC  = 4'd6,
        KIND_SOS  = 4'd7,
        KIND_PM   = 4'd8,
        KIND_APC  = 4'd9
    } t_seq_kind;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_TRAIL = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    // Control part of the parser state; the two number accumulators travel separately
    // because their width follows the parameter.
    typedef struct packed {
        t_seq_kind  kind;
        t_phase     phase;
        logic       any_param;
        logic       lead_is_digit;
        logic [3:0] lead_digit;
    } t_parse_state;

    typedef struct packed {
        logic      consumed;
        logic      done;
        t_seq_kind kind;
    } t_res_ctl;

    localparam t_parse_state PARSE_IDLE = '{
        kind:          KIND_NONE,
        phase:         PH_LEAD,
        any_param:     1'b0,
        lead_is_digit: 1'b0,
        lead_digit:    4'd0
    };

endpackage

>>> design/acsi_core.sv
module acsi_core #(
    parameter int PW = acsi_pkg::PARAM_WIDTH_DEF
) (
    input  logic [7:0]             i_byte,
    input  acsi_pkg::t_parse_state i_state,
    input  logic [PW-1:0]          i_lead,
    input  logic [PW-1:0]          i_trail,
    output acsi_pkg::t_parse_state o_state,
    output logic [PW-1:0]          o_lead,
    output logic [PW-1:0]          o_trail,
    output acsi_pkg::t_res_ctl     o_res,
    output logic [7:0]             o_final_byte,
    output logic [15:0]            o_first_param,
    output logic [15:0]            o_second_param
);
    import acsi_pkg::*;

    localparam logic [PW-1:0] LIMIT = {PW{1'b1}};

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    // Multiply by ten as two shifts and add the digit, then clamp.
    function automatic logic [PW-1:0] push_digit(input logic [PW-1:0] acc,
                                                 input logic [3:0] d);
        logic [PW+3:0] sum;
        sum = (PW+4)'({acc, 3'b000}) + (PW+4)'({acc, 1'b0}) + (PW+4)'(d);
        if (sum > (PW+4)'(LIMIT)) begin
            return LIMIT;
        end
        return sum[PW-1:0];
    endfunction

    function automatic t_seq_kind intro_kind(input logic [7:0] b);
        t_seq_kind k;
        unique case (b)
            8'h4E:   k = KIND_SS2;
            8'h4F:   k = KIND_SS3;
            8'h50:   k = KIND_DCS;
            8'h5B:   k = KIND_CSI;
            8'h5C:   k = KIND_ST;
            8'h5D:   k = KIND_OSC;
            8'h58:   k = KIND_SOS;
            8'h5E:   k = KIND_PM;
            8'h5F:   k = KIND_APC;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    logic          is_digit;
    logic [3:0]    digit;
    t_seq_kind     intro;
    logic          is_final;
    logic [PW-1:0] p0;
    logic [PW-1:0] p1;

    assign is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign digit    = is_digit ? 4'(i_byte - CH_0) : 4'd0;
    assign intro    = intro_kind(i_byte);

    always_comb begin
        o_state      = i_state;
        o_lead       = i_lead;
        o_trail      = i_trail;
        o_res        = '{consumed: 1'b0, done: 1'b0, kind: KIND_NONE};
        o_final_byte = 8'd0;
        is_final     = 1'b0;
        p0           = '0;
        p1           = '0;

        if (i_state.kind == KIND_NONE) begin
            if (intro != KIND_NONE) begin
                o_state      = PARSE_IDLE;
                o_state.kind = intro;
                o_lead       = '0;
                o_trail      = '0;
                o_res        = '{consumed: 1'b1, done: 1'b0, kind: intro};
            end
        end else if (i_state.kind != KIND_CSI) begin
            // Other introducers take no body: the next byte just closes them.
            o_state = PARSE_IDLE;
            o_lead  = '0;
            o_trail = '0;
        end else begin
            unique case (i_byte) inside
                8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
                8'h4A, 8'h4B, 8'h53, 8'h54, 8'h6D: begin
                    is_final = 1'b1;
                    p0       = i_state.lead_is_digit ? i_lead : PW'(1);
                end
                8'h48, 8'h66: begin
                    is_final = 1'b1;
                    p0       = i_lead;
                    p1       = i_state.any_param ? i_trail : '0;
                end
                8'h69, 8'h6E: begin
                    is_final = 1'b1;
                    p0       = i_state.lead_is_digit ? PW'(i_state.lead_digit) : '0;
                end
                default: begin
                    is_final = 1'b0;
                end
            endcase

            if (is_final) begin
                o_state      = PARSE_IDLE;
                o_lead       = '0;
                o_trail      = '0;
                o_res        = '{consumed: 1'b0, done: 1'b1, kind: KIND_CSI};
                o_final_byte = i_byte;
            end else begin
                if (!i_state.any_param) begin
                    o_state.lead_is_digit = is_digit;
                    o_state.lead_digit    = digit;
                end
                o_state.any_param = 1'b1;
                case (i_state.phase)
                    PH_LEAD: begin
                        if (is_digit) begin
                            o_lead = push_digit(i_lead, digit);
                        end else begin
                            o_state.phase = PH_TRAIL;
                        end
                    end
                    PH_TRAIL: begin
                        if (is_digit) begin
                            o_trail = push_digit(i_trail, digit);
                        end else begin
                            o_state.phase = PH_DONE;
                        end
                    end
                    default: begin
                        o_state.phase = i_state.phase;
                    end
                endcase
                o_res = '{consumed: 1'b1, done: 1'b0, kind: KIND_CSI};
            end
        end
    end

    assign o_first_param  = 16'(p0);
    assign o_second_param = 16'(p1);

endmodule

>>> design/ansi_csi_escape_parser.sv
// Parses the bytes that follow an escape character, one byte per clock while the output
// is not stalled. Every accepted byte yields exactly one result transfer: the byte passes
// an input register, the decode and number update run combinationally, and the result
// lands in an output register. Numbers are accumulated PARAM_WIDTH bits wide and
// saturate at all ones; the parameter outputs carry their low 16 bits. A stalled output
// holds its result while the input register still takes the next byte, so the input
// stalls only when both registers are full.
module ansi_csi_escape_parser #(
    parameter int PARAM_WIDTH = acsi_pkg::PARAM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_consumed,
    output logic        o_done_res,
    output logic [3:0]  o_seq_kind,
    output logic [7:0]  o_final_byte,
    output logic [15:0] o_first_param,
    output logic [15:0] o_second_param
);
    import acsi_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    t_parse_state           r_state;
    logic [PARAM_WIDTH-1:0] r_lead;
    logic [PARAM_WIDTH-1:0] r_trail;
    logic                   r_out_valid;
    t_res_ctl               r_out_res;
    logic [7:0]             r_out_final;
    logic [15:0]            r_out_p0;
    logic [15:0]            r_out_p1;

    t_parse_state           n_state;
    logic [PARAM_WIDTH-1:0] n_lead;
    logic [PARAM_WIDTH-1:0] n_trail;
    t_res_ctl               n_res;
    logic [7:0]             n_final;
    logic [15:0]            n_p0;
    logic [15:0]            n_p1;

    logic out_load;
    logic advance;
    logic in_take;

    assign out_load = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_load;
    assign o_stall  = r_in_valid && !out_load;
    assign in_take  = i_valid && !o_stall;

    acsi_core #(
        .PW(PARAM_WIDTH)
    ) u_core (
        .i_byte         (r_in_byte),
        .i_state        (r_state),
        .i_lead         (r_lead),
        .i_trail        (r_trail),
        .o_state        (n_state),
        .o_lead         (n_lead),
        .o_trail        (n_trail),
        .o_res          (n_res),
        .o_final_byte   (n_final),
        .o_first_param  (n_p0),
        .o_second_param (n_p1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_byte <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_IDLE;
            r_lead  <= '0;
            r_trail <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_lead  <= n_lead;
            r_trail <= n_trail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
        if (advance) begin
            r_out_res   <= n_res;
            r_out_final <= n_final;
            r_out_p0    <= n_p0;
            r_out_p1    <= n_p1;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_consumed     = r_out_res.consumed;
    assign o_done_res     = r_out_res.done;
    assign o_seq_kind     = r_out_res.kind;
    assign o_final_byte   = r_out_final;
    assign o_first_param  = r_out_p0;
    assign o_second_param = r_out_p1;

    // A completed sequence always leaves the parser idle.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_res.done |=> r_state.kind == KIND_NONE)
        else $error("parser not idle after a completed sequence");

    // A non-CSI introducer closes on the next byte with an empty result, neither consumed nor done.
    a_short_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_state.kind != KIND_NONE && r_state.kind != KIND_CSI
        |=> r_state.kind == KIND_NONE && r_out_valid && !r_out_res.consumed
            && !r_out_res.done)
        else $error("non-CSI introducer did not close cleanly");

    a_done_not_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.done |-> !r_out_res.consumed
            && r_out_res.kind == KIND_CSI)
        else $error("completed result marked as consumed");

    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.kind == KIND_NONE
        |-> !r_out_res.consumed && !r_out_res.done && r_out_final == 8'd0)
        else $error("empty result carries data");

    a_stall_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled without a full pipeline");

endmodule
